FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper with irq counter.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // item kinds
    localparam logic [2:0] F_WRITE = 3'd0;
    localparam logic [2:0] F_TICK  = 3'd1;
    localparam logic [2:0] F_LINE  = 3'd2;
    localparam logic [2:0] F_PRG   = 3'd3;
    localparam logic [2:0] F_CHR   = 3'd4;

    // write decode key: {addr[15:12], addr[0]}
    localparam logic [4:0] K_COMMAND = 5'h10;
    localparam logic [4:0] K_BANK    = 5'h11;
    localparam logic [4:0] K_MIRROR  = 5'h14;
    localparam logic [4:0] K_LATCH   = 5'h18;
    localparam logic [4:0] K_RELOAD  = 5'h19;
    localparam logic [4:0] K_IRQ_OFF = 5'h1C;
    localparam logic [4:0] K_IRQ_ON  = 5'h1D;

    localparam int         NUM_BANKS   = 11;
    localparam logic [3:0] BANK_TOP    = 4'd10;
    localparam logic [3:0] BANK_ALIAS  = 4'hF;
    localparam logic [3:0] BANK_PRG0   = 4'd6;
    localparam logic [3:0] BANK_PRG1   = 4'd7;
    localparam logic [3:0] BANK_CHR1   = 4'd8;
    localparam logic [3:0] BANK_CHR3   = 4'd9;
    localparam logic [7:0] BANK_RESET  = 8'hFF;
    localparam logic [7:0] LAST_BANK   = 8'hFF;
    localparam logic [8:0] SKIP_LINE   = 9'd240;
    localparam int         CMD_CHR1K   = 5;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic left_nz;
        logic left_one;
    } t_sts;

endpackage

FILE: sv/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_if
// Request and result channels of the bank mapper.
// ----------------------------------------------------------------------------
interface cbm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [15:0] addr;
    logic [7:0] data;
    logic [5:0] cycles;
    logic [8:0] scanline;

    modport source (output valid, func, addr, data, cycles, scanline, input ready);
    modport sink   (input valid, func, addr, data, cycles, scanline, output ready);
endinterface

interface cbm_out_if;
    logic       valid;
    logic       ready;
    logic       irq_line;
    logic       mirroring;
    logic [7:0] bank;
    logic       bank_valid;

    modport source (output valid, irq_line, mirroring, bank, bank_valid, input ready);
    modport sink   (input valid, irq_line, mirroring, bank, bank_valid, output ready);
endinterface

FILE: sv/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Sequencer: accept a request, execute it, run counter steps, hold result.
// ----------------------------------------------------------------------------
module cbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cbm_pkg::t_sts i_sts,
    output cbm_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.left_nz ? S_TICK : S_DONE;
            end
            S_TICK: begin
                o_cmd.step = 1'b1;
                if (i_sts.left_one) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("result pending while request accepted");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("accepted request not executed");
    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && i_sts.left_one) |=> o_out_valid)
        else $error("counter run did not finish");
    a_step_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_sts.left_nz)
        else $error("counter step with no steps left");
`endif

endmodule

FILE: sv/cbm_dp.sv
// ----------------------------------------------------------------------------
// cbm_dp
// Mapper state, write decode, irq counter and bank lookup.
// ----------------------------------------------------------------------------
module cbm_dp #(
    parameter int MAX_TICK_CYCLES = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbm_pkg::t_cmd i_cmd,
    output cbm_pkg::t_sts o_sts,
    input  logic [2:0]    i_func,
    input  logic [15:0]   i_addr,
    input  logic [7:0]    i_data,
    input  logic [5:0]    i_cycles,
    input  logic [8:0]    i_scanline,
    output logic          o_irq_line,
    output logic          o_mirroring,
    output logic [7:0]    o_bank,
    output logic          o_bank_valid
);

    localparam int MW = $clog2(MAX_TICK_CYCLES + 1);
    localparam int CW = (MW > 6) ? MW : 6;
    localparam int TW = CW + 1;
    localparam int LW = TW - 2;
    localparam logic [CW-1:0] MaxC = CW'(MAX_TICK_CYCLES);

    // request capture
    logic [2:0]  r_func;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic [8:0]  r_line;

    // mapper state
    logic [7:0] r_command,   n_command;
    logic [7:0] r_banks [cbm_pkg::NUM_BANKS];
    logic       r_mirror,    n_mirror;
    logic       r_reload,    n_reload;
    logic       r_cyc_mode,  n_cyc_mode;
    logic [7:0] r_counter,   n_counter;
    logic       r_irq_en,    n_irq_en;
    logic [7:0] r_latch,     n_latch;
    logic [1:0] r_presc,     n_presc;
    logic       r_pending,   n_pending;
    logic [LW-1:0] r_left,   n_left;
    logic [7:0] r_bank,      n_bank;
    logic       r_bvalid,    n_bvalid;

    logic          bank_we;
    logic [3:0]    bank_wa;
    logic [3:0]    rd_idx;
    logic [7:0]    rd_val;
    logic          pair_lo;
    logic          pair_mode;
    logic [CW-1:0] clamp_c;
    logic [TW-1:0] total;
    logic [4:0]    wkey;
    logic [2:0]    slot;
    logic          wrap;

    assign wkey    = {r_addr[15:12], r_addr[0]};
    assign slot    = r_addr[12:10];
    assign wrap    = (r_counter == 8'd0) && r_irq_en;
    assign clamp_c = (CW'(i_cycles) > MaxC) ? MaxC : CW'(i_cycles);
    assign total   = TW'(r_presc) + TW'(clamp_c);

    // bank read port
    always_comb begin
        rd_idx    = cbm_pkg::BANK_PRG0;
        pair_mode = 1'b0;
        pair_lo   = 1'b0;
        if (r_func == cbm_pkg::F_PRG) begin
            case (r_addr[14:13])
                2'd0:    rd_idx = cbm_pkg::BANK_PRG0;
                2'd1:    rd_idx = cbm_pkg::BANK_PRG1;
                default: rd_idx = cbm_pkg::BANK_TOP;
            endcase
        end else if (slot[2]) begin
            rd_idx = 4'({1'b0, slot} - 4'd2);
        end else if (r_command[cbm_pkg::CMD_CHR1K]) begin
            case (slot[1:0])
                2'd0:    rd_idx = 4'd0;
                2'd1:    rd_idx = cbm_pkg::BANK_CHR1;
                2'd2:    rd_idx = 4'd1;
                default: rd_idx = cbm_pkg::BANK_CHR3;
            endcase
        end else begin
            rd_idx    = {3'd0, slot[1]};
            pair_mode = 1'b1;
            pair_lo   = slot[0];
        end
        rd_val = (rd_idx <= cbm_pkg::BANK_TOP) ? r_banks[rd_idx] : 8'd0;
    end

    always_comb begin
        n_command  = r_command;
        n_mirror   = r_mirror;
        n_reload   = r_reload;
        n_cyc_mode = r_cyc_mode;
        n_counter  = r_counter;
        n_irq_en   = r_irq_en;
        n_latch    = r_latch;
        n_presc    = r_presc;
        n_pending  = r_pending;
        n_left     = r_left;
        n_bank     = r_bank;
        n_bvalid   = r_bvalid;
        bank_we    = 1'b0;
        bank_wa    = r_command[3:0];

        if (i_cmd.load) begin
            n_left = '0;
            if (i_func == cbm_pkg::F_TICK && r_cyc_mode) begin
                n_presc = total[1:0];
                n_left  = total[TW-1:2];
            end
        end

        if (i_cmd.exec) begin
            n_bank   = 8'd0;
            n_bvalid = 1'b0;
            case (r_func)
                cbm_pkg::F_WRITE: begin
                    case (wkey)
                        cbm_pkg::K_COMMAND: n_command = r_data;
                        cbm_pkg::K_BANK: begin
                            if (r_command[3:0] < cbm_pkg::BANK_TOP) begin
                                bank_we = 1'b1;
                            end else if (r_command[3:0] == cbm_pkg::BANK_ALIAS) begin
                                bank_we = 1'b1;
                                bank_wa = cbm_pkg::BANK_TOP;
                            end
                        end
                        cbm_pkg::K_MIRROR: n_mirror = r_data[0];
                        cbm_pkg::K_LATCH: begin
                            n_latch = r_data;
                            if (r_reload) n_counter = r_data;
                        end
                        cbm_pkg::K_RELOAD: begin
                            n_reload   = 1'b1;
                            n_counter  = r_latch;
                            n_cyc_mode = r_data[0];
                        end
                        cbm_pkg::K_IRQ_OFF: begin
                            n_irq_en  = 1'b0;
                            n_pending = 1'b0;
                            if (r_reload) n_counter = r_latch;
                        end
                        cbm_pkg::K_IRQ_ON: begin
                            n_irq_en = 1'b1;
                            if (r_reload) n_counter = r_latch;
                        end
                        default: ;
                    endcase
                end
                cbm_pkg::F_LINE: begin
                    if (!r_cyc_mode && r_line != cbm_pkg::SKIP_LINE) begin
                        n_counter = r_counter - 8'd1;
                        n_reload  = wrap;
                        if (wrap) n_pending = 1'b1;
                    end
                end
                cbm_pkg::F_PRG: begin
                    if (r_addr[15]) begin
                        n_bvalid = 1'b1;
                        n_bank   = (r_addr[14:13] == 2'd3) ? cbm_pkg::LAST_BANK : rd_val;
                    end
                end
                cbm_pkg::F_CHR: begin
                    if (r_addr[15:13] == 3'd0) begin
                        n_bvalid = 1'b1;
                        n_bank   = pair_mode ? {rd_val[7:1], pair_lo} : rd_val;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.step) begin
            n_counter = r_counter - 8'd1;
            n_left    = r_left - LW'(1);
            if (wrap) n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_addr <= i_addr;
            r_data <= i_data;
            r_line <= i_scanline;
        end
        r_bank   <= n_bank;
        r_bvalid <= n_bvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command  <= 8'd0;
            r_mirror   <= 1'b0;
            r_reload   <= 1'b0;
            r_cyc_mode <= 1'b0;
            r_counter  <= 8'd0;
            r_irq_en   <= 1'b0;
            r_latch    <= 8'd0;
            r_presc    <= 2'd0;
            r_pending  <= 1'b0;
            r_left     <= '0;
            for (int i = 0; i < cbm_pkg::NUM_BANKS; i++) begin
                r_banks[i] <= cbm_pkg::BANK_RESET;
            end
        end else begin
            r_command  <= n_command;
            r_mirror   <= n_mirror;
            r_reload   <= n_reload;
            r_cyc_mode <= n_cyc_mode;
            r_counter  <= n_counter;
            r_irq_en   <= n_irq_en;
            r_latch    <= n_latch;
            r_presc    <= n_presc;
            r_pending  <= n_pending;
            r_left     <= n_left;
            if (bank_we) begin
                r_banks[bank_wa] <= r_data;
            end
        end
    end

    assign o_sts.left_nz  = (r_left != '0);
    assign o_sts.left_one = (r_left == LW'(1));
    assign o_irq_line     = r_pending;
    assign o_mirroring    = ~r_mirror;
    assign o_bank         = r_bank;
    assign o_bank_valid   = r_bvalid;

`ifndef NO_ASSERTIONS
    a_wrap_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && wrap) |=> r_pending)
        else $error("counter wrap did not raise irq");
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_counter == $past(r_counter) - 8'd1))
        else $error("counter step lost");
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !r_cyc_mode) |=> !o_sts.left_nz)
        else $error("steps queued outside cycle mode");
`endif

endmodule

FILE: sv/cartridge_bank_mapper_irq_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_core
// Sequence: accept the request, execute it, then for a tick in cycle mode run
// N = (prescaler + min(cycles, MAX_TICK_CYCLES)) / 4 irq counter steps, one
// per clock (N is 0 otherwise and at most 16 with a 6-bit cycle count), and
// hold the result until taken; a new request is accepted only after that.
// Reset is synchronous, active low; all bank registers read 0xFF.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_core #(
    parameter int MAX_TICK_CYCLES = 63
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cbm_in_if.sink    i_in,
    cbm_out_if.source o_out
);

    cbm_pkg::t_cmd cmd;
    cbm_pkg::t_sts sts;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbm_dp #(
        .MAX_TICK_CYCLES (MAX_TICK_CYCLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_in.func),
        .i_addr       (i_in.addr),
        .i_data       (i_in.data),
        .i_cycles     (i_in.cycles),
        .i_scanline   (i_in.scanline),
        .o_irq_line   (o_out.irq_line),
        .o_mirroring  (o_out.mirroring),
        .o_bank       (o_out.bank),
        .o_bank_valid (o_out.bank_valid)
    );

endmodule
